[hdl/siphash_pkg.sv]
// Shared types, constants and the sip round function for the keyed SipHash block.
`timescale 1ns / 1ps

package siphash_pkg;

   localparam int WORD_W  = 64;
   localparam int COUNT_W = 4;
   localparam int ROUND_W = 4;
   localparam int LEN_W   = 8;
   localparam int CSR_W   = 2;

   localparam logic [WORD_W-1:0] INIT_A = 64'h736f6d6570736575;
   localparam logic [WORD_W-1:0] INIT_B = 64'h646f72616e646f6d;
   localparam logic [WORD_W-1:0] INIT_C = 64'h6c7967656e657261;
   localparam logic [WORD_W-1:0] INIT_D = 64'h7465646279746573;
   localparam logic [7:0]        FIN_MARK = 8'hff;
   localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd8;

   typedef enum logic [CSR_W-1:0] {
      CSR_KEY_LOW   = 2'd0,
      CSR_KEY_HIGH  = 2'd1,
      CSR_CMP_ROUND = 2'd2,
      CSR_FIN_ROUND = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] c;
      logic [WORD_W-1:0] d;
   } lanes_type;

   typedef struct packed {
      logic load;       // take the input word: init lanes if needed, xor block into d
      logic tail_load;  // xor the length-only tail block into d
      logic round_en;   // run one sip round
      logic end_xor;    // xor the held block into a
      logic fin_xor;    // xor the finalisation mark into c
      logic emit;       // register the hash
   } dp_cmd_type;

   typedef struct packed {
      logic [ROUND_W-1:0] cmp_rounds;
      logic [ROUND_W-1:0] fin_rounds;
      logic               blk_full;
   } dp_status_type;

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int n);
      rotl = (x << n) | (x >> (WORD_W - n));
   endfunction

   function automatic lanes_type sip_round(input lanes_type v);
      lanes_type r;
      r = v;
      r.a = r.a + r.b;
      r.c = r.c + r.d;
      r.b = rotl(r.b, 13);
      r.d = rotl(r.d, 16);
      r.b = r.b ^ r.a;
      r.d = r.d ^ r.c;
      r.a = rotl(r.a, 32);
      r.c = r.c + r.b;
      r.a = r.a + r.d;
      r.b = rotl(r.b, 17);
      r.d = rotl(r.d, 21);
      r.b = r.b ^ r.c;
      r.d = r.d ^ r.a;
      r.c = rotl(r.c, 32);
      sip_round = r;
   endfunction

endpackage

[hdl/siphash_c_d_keyed_hash.sv]
// Top level of the keyed SipHash-c-d block: controller, datapath and checks.
`timescale 1ns / 1ps

// Keyed SipHash with programmable round counts (SipHash-2-4 after reset).
// Message words arrive on req_ as little-endian 64-bit words; req_tlast marks
// the last word, whose byte count (0 to 8, larger values taken as 8) gives the
// tail length. One 64-bit hash leaves on rsp_ per message. One sip round runs
// per cycle in the shared round unit, which runs a word's compression rounds
// before the next word is taken. The last word then runs the finalization
// rounds and registers the hash; a full last word first adds a length-only
// block with its own compression rounds. A finished hash waits in the output
// register while the next message is taken in; the block stalls only if a
// second hash is ready before the first one has been transferred. Key and
// round counts are written through csr_, by the user only while the block is
// idle, unchecked by the block; the key is read at a message's first word.
module siphash_c_d_keyed_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // message_word[63:0], byte_count[67:64], zero pad
   input  logic        req_tlast,   // last_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // hash_value[63:0]
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import siphash_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          in_msg;

   siphash_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd),
      .in_msg     (in_msg)
   );

   siphash_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .message_word (req_tdata[WORD_W-1:0]),
      .byte_count   (req_tdata[WORD_W+COUNT_W-1:WORD_W]),
      .last_word    (req_tlast),
      .in_msg       (in_msg),
      .cmd          (cmd),
      .status       (status),
      .hash_value   (rsp_tdata)
   );

`ifndef SYNTHESIS
   a_ready_no_work: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !cmd.round_en && !cmd.end_xor && !cmd.tail_load && !cmd.emit)
      else $error("round unit busy while taking input");

   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("input taken straight after a last word");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !rsp_tvalid || rsp_tready)
      else $error("hash overwritten before transfer");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_tvalid)
      else $error("hash registered without valid");

   a_cmd_single: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.tail_load, cmd.round_en || cmd.end_xor, cmd.emit}))
      else $error("conflicting datapath commands");
`endif

endmodule

[hdl/siphash_dp.sv]
// Datapath: key and round-count registers, the four lanes, block and length registers, hash.
`timescale 1ns / 1ps

module siphash_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [siphash_pkg::CSR_W-1:0]       csr_index,
   input  logic [siphash_pkg::WORD_W-1:0]      csr_wdata,
   input  logic [siphash_pkg::WORD_W-1:0]      message_word,
   input  logic [siphash_pkg::COUNT_W-1:0]     byte_count,
   input  logic                                last_word,
   input  logic                                in_msg,
   input  siphash_pkg::dp_cmd_type             cmd,
   output siphash_pkg::dp_status_type          status,
   output logic [siphash_pkg::WORD_W-1:0]      hash_value
);
   import siphash_pkg::*;

   logic [WORD_W-1:0]  key_low_ff;
   logic [WORD_W-1:0]  key_high_ff;
   logic [ROUND_W-1:0] cmp_rounds_ff;
   logic [ROUND_W-1:0] fin_rounds_ff;

   lanes_type          lanes_ff, lanes_in;
   lanes_type          base_lanes, stepped;
   logic [WORD_W-1:0]  blk_ff, blk_in;
   logic               blk_full_ff, blk_full_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [WORD_W-1:0]  hash_ff;

   logic [COUNT_W-1:0] cnt_sat;
   logic               full;
   logic [LEN_W-1:0]   len_base;
   logic [LEN_W-1:0]   len_new;
   logic [WORD_W-1:0]  tail_mask;
   logic [WORD_W-1:0]  load_blk;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff    <= '0;
         key_high_ff   <= '0;
         cmp_rounds_ff <= 4'd2;
         fin_rounds_ff <= 4'd4;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_KEY_LOW:   key_low_ff    <= csr_wdata;
            CSR_KEY_HIGH:  key_high_ff   <= csr_wdata;
            CSR_CMP_ROUND: cmp_rounds_ff <= csr_wdata[ROUND_W-1:0];
            CSR_FIN_ROUND: fin_rounds_ff <= csr_wdata[ROUND_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cnt_sat   = (byte_count > FULL_COUNT) ? FULL_COUNT : byte_count;
      full      = !last_word || (cnt_sat == FULL_COUNT);
      len_base  = in_msg ? len_ff : '0;
      len_new   = full ? (len_base + LEN_W'(FULL_COUNT))
                       : (len_base + {{(LEN_W-COUNT_W){1'b0}}, cnt_sat});
      tail_mask = (64'd1 << {cnt_sat[2:0], 3'b000}) - 64'd1;
      load_blk  = full ? message_word
                       : ((message_word & tail_mask) | {len_new, {(WORD_W-LEN_W){1'b0}}});

      if (in_msg) begin
         base_lanes = lanes_ff;
      end else begin
         base_lanes.a = key_low_ff  ^ INIT_A;
         base_lanes.b = key_high_ff ^ INIT_B;
         base_lanes.c = key_low_ff  ^ INIT_C;
         base_lanes.d = key_high_ff ^ INIT_D;
      end

      stepped = cmd.round_en ? sip_round(lanes_ff) : lanes_ff;
      if (cmd.end_xor) begin
         stepped.a = stepped.a ^ blk_ff;
      end
      if (cmd.fin_xor) begin
         stepped.c = stepped.c ^ {{(WORD_W-8){1'b0}}, FIN_MARK};
      end

      lanes_in    = stepped;
      blk_in      = blk_ff;
      blk_full_in = blk_full_ff;
      len_in      = len_ff;
      if (cmd.load) begin
         lanes_in    = base_lanes;
         lanes_in.d  = base_lanes.d ^ load_blk;
         blk_in      = load_blk;
         blk_full_in = last_word && full;
         len_in      = len_new;
      end else if (cmd.tail_load) begin
         blk_in      = {len_ff, {(WORD_W-LEN_W){1'b0}}};
         lanes_in.d  = lanes_ff.d ^ blk_in;
         blk_full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      lanes_ff <= lanes_in;
      blk_ff   <= blk_in;
      len_ff   <= len_in;
      if (cmd.emit) begin
         hash_ff <= lanes_ff.a ^ lanes_ff.b ^ lanes_ff.c ^ lanes_ff.d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_full_ff <= 1'b0;
      end else begin
         blk_full_ff <= blk_full_in;
      end
   end

   assign status.cmp_rounds = cmp_rounds_ff;
   assign status.fin_rounds = fin_rounds_ff;
   assign status.blk_full   = blk_full_ff;
   assign hash_value        = hash_ff;

endmodule

[hdl/siphash_ctrl.sv]
// Controller: message framing, round counting and result hand-off.
`timescale 1ns / 1ps

module siphash_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tlast,
   output logic                        req_tready,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  siphash_pkg::dp_status_type  status,
   output siphash_pkg::dp_cmd_type     cmd,
   output logic                        in_msg
);
   import siphash_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ABSORB,
      ST_TAIL,
      ST_FINAL,
      ST_EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic [ROUND_W-1:0] cnt_ff, cnt_in;
   logic               last_ff, last_in;
   logic               in_msg_ff, in_msg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               accept;
   logic               absorb_end;
   logic               out_free;

   assign accept     = (state_ff == ST_IDLE) && req_tvalid;
   assign absorb_end = (cnt_ff <= ROUND_W'(1));
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      in_msg_in    = in_msg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load  = 1'b1;
               cnt_in    = status.cmp_rounds;
               last_in   = req_tlast;
               in_msg_in = !req_tlast;
               state_in  = ST_ABSORB;
            end
         end
         ST_ABSORB: begin
            cmd.round_en = (cnt_ff != '0);
            cmd.end_xor  = absorb_end;
            if (!absorb_end) begin
               cnt_in = cnt_ff - ROUND_W'(1);
            end else if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (status.blk_full) begin
               state_in = ST_TAIL;
            end else begin
               cmd.fin_xor = 1'b1;
               cnt_in      = status.fin_rounds;
               state_in    = (status.fin_rounds == '0) ? ST_EMIT : ST_FINAL;
            end
         end
         ST_TAIL: begin
            cmd.tail_load = 1'b1;
            cnt_in        = status.cmp_rounds;
            state_in      = ST_ABSORB;
         end
         ST_FINAL: begin
            cmd.round_en = 1'b1;
            cnt_in       = cnt_ff - ROUND_W'(1);
            if (cnt_ff == ROUND_W'(1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         last_ff      <= 1'b0;
         in_msg_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         last_ff      <= last_in;
         in_msg_ff    <= in_msg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign in_msg     = in_msg_ff;

endmodule
